@@ hdl/bma_pkg.sv @@
// Shared constants and types for the boxcar moving average block.
`timescale 1ns / 1ps

package bma_pkg;

    localparam int DEF_MAX_WINDOW = 16;
    localparam int SAMPLE_W       = 16;
    localparam int AVG_W          = 24;
    localparam int HELD_W         = 5;
    localparam int CFG_W          = 5;
    localparam int FRAC_W         = 8;
    localparam int CFG_RESET      = 16;
    localparam int QUEUE_DEPTH    = 2;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_READ,
        ST_UPDATE,
        ST_DIV
    } t_state;

    typedef struct packed {
        logic busy;
        logic done;
    } t_div_stat;

endpackage

@@ hdl/bma_front.sv @@
// Input side: accepts sample requests into a short queue ahead of the window logic.
`timescale 1ns / 1ps

module bma_front (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bma_pkg::SAMPLE_W-1:0] i_sample,
    output logic                         o_q_valid,
    output logic [bma_pkg::SAMPLE_W-1:0] o_q_sample,
    input  logic                         i_q_pop
);
    import bma_pkg::*;

    localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

    logic [SAMPLE_W-1:0] r_mem [QUEUE_DEPTH];
    logic [QPTR_W-1:0]   r_wr_ptr;
    logic [QPTR_W-1:0]   r_rd_ptr;
    logic [QCNT_W-1:0]   r_count;
    logic                push;
    logic                pop;

    assign o_ready    = (r_count != QCNT_W'(QUEUE_DEPTH));
    assign o_q_valid  = (r_count != '0);
    assign o_q_sample = r_mem[r_rd_ptr];
    assign push       = i_valid && o_ready;
    assign pop        = i_q_pop && o_q_valid;

    function automatic logic [QPTR_W-1:0] ptr_inc(input logic [QPTR_W-1:0] p);
        return (p == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : p + QPTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (push) begin
                r_wr_ptr <= ptr_inc(r_wr_ptr);
            end
            if (pop) begin
                r_rd_ptr <= ptr_inc(r_rd_ptr);
            end
            if (push && !pop) begin
                r_count <= r_count + QCNT_W'(1);
            end else if (pop && !push) begin
                r_count <= r_count - QCNT_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push) begin
            r_mem[r_wr_ptr] <= i_sample;
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count exceeds depth");

endmodule

@@ hdl/bma_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
`timescale 1ns / 1ps

module bma_div #(
    parameter int DIVD_W = 28,
    parameter int DVSR_W = 5
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_start,
    input  logic [DIVD_W-1:0]  i_dividend,
    input  logic [DVSR_W-1:0]  i_divisor,
    output logic [DIVD_W-1:0]  o_quotient,
    output bma_pkg::t_div_stat o_stat
);
    import bma_pkg::*;

    localparam int CNT_W = $clog2(DIVD_W + 1);

    logic              r_busy;
    logic              r_done;
    logic [CNT_W-1:0]  r_cnt;
    logic [DIVD_W-1:0] r_quo;
    logic [DVSR_W-1:0] r_rem;
    logic [DVSR_W-1:0] r_dvsr;
    logic [DVSR_W:0]   rem_sh;
    logic [DVSR_W:0]   rem_sub;
    logic              ge;

    // The quotient register doubles as the dividend shifter: its top bit feeds
    // the partial remainder while the new quotient bit enters at the bottom.
    assign rem_sh  = {r_rem, r_quo[DIVD_W-1]};
    assign ge      = (rem_sh >= {1'b0, r_dvsr});
    assign rem_sub = rem_sh - {1'b0, r_dvsr};

    assign o_quotient  = r_quo;
    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_done <= 1'b0;
            r_cnt  <= CNT_W'(DIVD_W);
        end else if (r_busy) begin
            r_cnt <= r_cnt - CNT_W'(1);
            if (r_cnt == CNT_W'(1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_quo  <= i_dividend;
            r_rem  <= '0;
            r_dvsr <= i_divisor;
        end else if (r_busy) begin
            r_rem <= ge ? rem_sub[DVSR_W-1:0] : rem_sh[DVSR_W-1:0];
            r_quo <= {r_quo[DIVD_W-2:0], ge};
        end
    end

    a_busy_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(r_busy && r_done))
        else $error("divider busy and done together");

endmodule

@@ hdl/bma_core.sv @@
// Window logic: sample store, running sum, fill count, divider and result register.
`timescale 1ns / 1ps

module bma_core #(
    parameter int MAX_WINDOW = bma_pkg::DEF_MAX_WINDOW
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bma_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                         i_q_valid,
    input  logic [bma_pkg::SAMPLE_W-1:0] i_q_sample,
    output logic                         o_q_pop,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bma_pkg::AVG_W-1:0]    o_average,
    output logic [bma_pkg::HELD_W-1:0]   o_samples_held
);
    import bma_pkg::*;

    // The length register is five bits wide, so no window beyond its range is usable.
    localparam int LEN_CAP = (1 << CFG_W) - 1;
    localparam int EFF_MAX = (MAX_WINDOW < LEN_CAP) ? MAX_WINDOW : LEN_CAP;
    localparam int CNT_W   = $clog2(EFF_MAX + 1);
    localparam int IDX_W   = $clog2(EFF_MAX);
    localparam int SUM_W   = SAMPLE_W + $clog2(EFF_MAX);
    localparam int DIVD_W  = SUM_W + FRAC_W;

    function automatic logic [CNT_W-1:0] clamp_len(input logic [CFG_W-1:0] w);
        logic [CNT_W-1:0] res;
        if (w == '0) begin
            res = CNT_W'(1);
        end else if (int'(w) > EFF_MAX) begin
            res = CNT_W'(EFF_MAX);
        end else begin
            res = CNT_W'(w);
        end
        return res;
    endfunction

    t_state              r_state;
    t_state              n_state;
    logic [CNT_W-1:0]    r_len;
    logic [IDX_W-1:0]    r_idx;
    logic [CNT_W-1:0]    r_fill;
    logic [SUM_W-1:0]    r_sum;
    logic [SAMPLE_W-1:0] r_sample;
    logic [SAMPLE_W-1:0] r_old;
    logic [SAMPLE_W-1:0] r_store [EFF_MAX];
    logic                r_out_valid;
    logic [AVG_W-1:0]    r_avg;
    logic [HELD_W-1:0]   r_held;

    logic                pop;
    logic                div_start;
    logic                load_out;
    logic                full;
    logic [SUM_W-1:0]    sum_base;
    logic [SUM_W-1:0]    n_sum;
    logic [CNT_W-1:0]    n_fill;
    logic [CNT_W-1:0]    idx_inc;
    logic [IDX_W-1:0]    n_idx;
    logic [DIVD_W-1:0]   quotient;
    t_div_stat           div_stat;

    // Once the window is full the oldest sample leaves the sum as the new one enters.
    assign full     = (r_fill >= r_len);
    assign sum_base = full ? (r_sum - SUM_W'(r_old)) : r_sum;
    assign n_sum    = sum_base + SUM_W'(r_sample);
    assign n_fill   = full ? r_len : (r_fill + CNT_W'(1));
    assign idx_inc  = CNT_W'(r_idx) + CNT_W'(1);
    assign n_idx    = (idx_inc >= r_len) ? '0 : idx_inc[IDX_W-1:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        pop       = 1'b0;
        div_start = 1'b0;
        load_out  = 1'b0;
        unique case (r_state)
            ST_IDLE: begin
                if (i_q_valid) begin
                    pop     = 1'b1;
                    n_state = ST_READ;
                end
            end
            ST_READ: begin
                n_state = ST_UPDATE;
            end
            ST_UPDATE: begin
                div_start = 1'b1;
                n_state   = ST_DIV;
            end
            ST_DIV: begin
                if (div_stat.done && (!r_out_valid || i_ready)) begin
                    load_out = 1'b1;
                    n_state  = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_len       <= clamp_len(CFG_W'(CFG_RESET));
            r_idx       <= '0;
            r_fill      <= '0;
            r_sum       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_len  <= clamp_len(i_cfg_wdata);
                r_idx  <= '0;
                r_fill <= '0;
                r_sum  <= '0;
            end else if (r_state == ST_UPDATE) begin
                r_idx  <= n_idx;
                r_fill <= n_fill;
                r_sum  <= n_sum;
            end
            if (load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_sample <= i_q_sample;
        end
        if (r_state == ST_READ) begin
            r_old <= r_store[r_idx];
        end
        if (r_state == ST_UPDATE) begin
            r_store[r_idx] <= r_sample;
        end
        if (load_out) begin
            r_avg  <= quotient[AVG_W-1:0];
            r_held <= HELD_W'(r_fill);
        end
    end

    bma_div #(
        .DIVD_W (DIVD_W),
        .DVSR_W (CNT_W)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend ({n_sum, FRAC_W'(0)}),
        .i_divisor  (n_fill),
        .o_quotient (quotient),
        .o_stat     (div_stat)
    );

    assign o_q_pop        = pop;
    assign o_valid        = r_out_valid;
    assign o_average      = r_avg;
    assign o_samples_held = r_held;

    a_fill_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_fill <= r_len)
        else $error("fill count beyond window length");

    a_idx_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        CNT_W'(r_idx) < r_len)
        else $error("write index outside window");

    a_held_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_held != '0))
        else $error("result shown with zero samples held");

endmodule

@@ hdl/boxcar_moving_average_top.sv @@
// Top level of the boxcar moving average filter.
`timescale 1ns / 1ps

// Boxcar moving average over the last window_length samples (1 to MAX_WINDOW, capped at 31;
// zero acts as one). Each accepted sample request yields one result: the mean of the samples
// held so far as unsigned Q16.8 (fraction truncated) and the number of samples it covers.
// A sample goes from the input queue through the read, update and divide states to the result
// register; one sample is handled at a time, the next popped once the last result is loaded.
// The radix-2 divider yields one quotient bit per cycle; its dividend is 24 + clog2(EFF_MAX) bits.
// A two-entry input queue and a result register let either side stall alone.
// Writing the length register clears the window; write it only while the block is idle.
module boxcar_moving_average_top #(
    parameter int MAX_WINDOW = bma_pkg::DEF_MAX_WINDOW
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_cfg_we,
    input  logic [bma_pkg::CFG_W-1:0]    i_cfg_wdata,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [bma_pkg::SAMPLE_W-1:0] i_sample,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic [bma_pkg::AVG_W-1:0]    o_average,
    output logic [bma_pkg::HELD_W-1:0]   o_samples_held
);
    import bma_pkg::*;

    logic                q_valid;
    logic [SAMPLE_W-1:0] q_sample;
    logic                q_pop;

    bma_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sample   (i_sample),
        .o_q_valid  (q_valid),
        .o_q_sample (q_sample),
        .i_q_pop    (q_pop)
    );

    bma_core #(
        .MAX_WINDOW (MAX_WINDOW)
    ) u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_q_valid      (q_valid),
        .i_q_sample     (q_sample),
        .o_q_pop        (q_pop),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_average      (o_average),
        .o_samples_held (o_samples_held)
    );

endmodule

@@ tb/boxcar_moving_average_top_tb.sv @@
// Self-checking testbench for the boxcar moving average filter.
`timescale 1ns / 1ps

module boxcar_moving_average_top_tb;
    import bma_pkg::*;

    localparam int WINDOW_MAX  = DEF_MAX_WINDOW;
    localparam int SLOT_W      = $clog2(WINDOW_MAX);
    localparam int CFG_TOP     = (1 << CFG_W) - 1;
    localparam int CYCLE_LIMIT = 500000;
    localparam int TAIL_CYCLES = 40;
    localparam int PHASE_ITEMS = 560;
    localparam int DIR_ROWS    = 29;
    localparam int ROW_W       = $clog2(DIR_ROWS);

    typedef struct packed {
        logic [AVG_W-1:0]  average;
        logic [HELD_W-1:0] held;
    } t_mean;

    typedef enum logic {
        ROW_CFG,
        ROW_SAMPLE
    } t_row_kind;

    typedef struct packed {
        t_row_kind            kind;
        logic [SAMPLE_W-1:0]  value;
        logic                 typed;
        t_mean                want;
    } t_dir_row;

    localparam t_mean NO_MEAN = '0;

    logic                i_clk          = 1'b0;
    logic                i_rst_n        = 1'b0;
    logic                i_cfg_we       = 1'b0;
    logic [CFG_W-1:0]    i_cfg_wdata    = '0;
    logic                i_valid        = 1'b0;
    logic                o_ready;
    logic [SAMPLE_W-1:0] i_sample       = '0;
    logic                o_valid;
    logic                i_ready        = 1'b0;
    logic [AVG_W-1:0]    o_average;
    logic [HELD_W-1:0]   o_samples_held;

    // Shadow copy of the filter state.
    logic [SAMPLE_W-1:0] held_samples [WINDOW_MAX];
    int unsigned         slot    = 0;
    int unsigned         fill    = 0;
    logic [31:0]         sum     = '0;
    logic [CFG_W-1:0]    win_reg = CFG_W'(CFG_RESET);

    t_mean       pending_means [$];
    int          send_idle_pct = 25;
    int          recv_idle_pct = 79;
    bit          valid_lowered = 1'b1;
    int          errors        = 0;
    int          checked       = 0;
    int          sent_total    = 0;
    int          cfg_writes    = 0;
    int unsigned cycles        = 0;

    t_dir_row directed [0:DIR_ROWS-1] = '{
        '{ROW_SAMPLE, 16'h0000, 1'b1, '{24'h000000, 5'd1}},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, '{24'h7FFF80, 5'd2}},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, NO_MEAN},
        '{ROW_CFG,    16'd1,    1'b0, NO_MEAN},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, '{24'hFFFF00, 5'd1}},
        '{ROW_SAMPLE, 16'h0000, 1'b1, '{24'h000000, 5'd1}},
        '{ROW_SAMPLE, 16'h1234, 1'b1, '{24'h123400, 5'd1}},
        '{ROW_CFG,    16'd0,    1'b0, NO_MEAN},
        '{ROW_SAMPLE, 16'hABCD, 1'b1, '{24'hABCD00, 5'd1}},
        '{ROW_SAMPLE, 16'h0001, 1'b1, '{24'h000100, 5'd1}},
        '{ROW_CFG,    16'd2,    1'b0, NO_MEAN},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, '{24'hFFFF00, 5'd1}},
        '{ROW_SAMPLE, 16'hFFFF, 1'b1, '{24'hFFFF00, 5'd2}},
        '{ROW_SAMPLE, 16'h0000, 1'b1, '{24'h7FFF80, 5'd2}},
        '{ROW_SAMPLE, 16'h0000, 1'b1, '{24'h000000, 5'd2}},
        '{ROW_CFG,    16'd31,   1'b0, NO_MEAN},
        '{ROW_SAMPLE, 16'h8000, 1'b1, '{24'h800000, 5'd1}},
        '{ROW_SAMPLE, 16'h8000, 1'b1, '{24'h800000, 5'd2}},
        '{ROW_SAMPLE, 16'h8000, 1'b1, '{24'h800000, 5'd3}},
        '{ROW_CFG,    16'd16,   1'b0, NO_MEAN},
        '{ROW_SAMPLE, 16'hFFFF, 1'b0, NO_MEAN},
        '{ROW_SAMPLE, 16'h0000, 1'b0, NO_MEAN},
        '{ROW_SAMPLE, 16'h5555, 1'b0, NO_MEAN},
        '{ROW_SAMPLE, 16'hAAAA, 1'b0, NO_MEAN},
        '{ROW_CFG,    16'd3,    1'b0, NO_MEAN},
        '{ROW_SAMPLE, 16'h0001, 1'b0, NO_MEAN},
        '{ROW_SAMPLE, 16'h0002, 1'b0, NO_MEAN},
        '{ROW_SAMPLE, 16'h0004, 1'b0, NO_MEAN},
        '{ROW_SAMPLE, 16'h0008, 1'b0, NO_MEAN}
    };

    boxcar_moving_average_top uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_we),
        .i_cfg_wdata    (i_cfg_wdata),
        .i_valid        (i_valid),
        .o_ready        (o_ready),
        .i_sample       (i_sample),
        .o_valid        (o_valid),
        .i_ready        (i_ready),
        .o_average      (o_average),
        .o_samples_held (o_samples_held)
    );

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    function automatic t_mean next_mean(input logic [SAMPLE_W-1:0] s);
        int unsigned len;
        logic [39:0] quot;
        t_mean       r;
        // A length of zero acts as one; anything above the store depth saturates.
        len = (win_reg == '0) ? 1 :
              ((int'(win_reg) > WINDOW_MAX) ? WINDOW_MAX : int'(win_reg));
        if (slot >= len) slot = 0;
        if (fill >= len) begin
            fill = len;
            sum  = sum - 32'(held_samples[slot[SLOT_W-1:0]]);
        end else begin
            fill++;
        end
        sum = sum + 32'(s);
        held_samples[slot[SLOT_W-1:0]] = s;
        slot++;
        if (slot >= len) slot = 0;
        quot = (40'(sum) << FRAC_W) / 40'(fill);
        if (quot > 40'hFFFFFF) quot = 40'hFFFFFF;
        r.average = quot[AVG_W-1:0];
        r.held    = fill[HELD_W-1:0];
        return r;
    endfunction

    function automatic logic [SAMPLE_W-1:0] random_sample();
        case ($urandom_range(0, 9))
            0: return '0;
            1: return '1;
            2: return SAMPLE_W'($urandom_range(0, 15));
            3: return SAMPLE_W'($urandom_range(16'hFFF0, 16'hFFFF));
            default: return SAMPLE_W'($urandom_range(0, 16'hFFFF));
        endcase
    endfunction

    task automatic wait_drain();
        while (pending_means.size() != 0) @(posedge i_clk);
    endtask

    task automatic write_window(input logic [CFG_W-1:0] len);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= len;
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        win_reg  = len;
        slot     = 0;
        fill     = 0;
        sum      = '0;
        cfg_writes++;
    endtask

    // Valid is only dropped right after a request is taken, so it never falls and
    // rises within one time step.
    task automatic send_sample(input logic [SAMPLE_W-1:0] s, input bit last,
                               input bit typed, input t_mean typed_mean);
        t_mean predicted;
        if (valid_lowered) begin
            do @(posedge i_clk); while ($urandom_range(0, 99) < send_idle_pct);
        end
        i_valid  <= 1'b1;
        i_sample <= s;
        do @(posedge i_clk); while (!o_ready);
        predicted = next_mean(s);
        pending_means.push_back(typed ? typed_mean : predicted);
        sent_total++;
        valid_lowered = last || ($urandom_range(0, 99) < send_idle_pct);
        if (valid_lowered) i_valid <= 1'b0;
    endtask

    task automatic run_phase(input int send_pct, input int recv_pct, input int n_items);
        int               sent;
        int               group;
        logic [CFG_W-1:0] len;
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        sent = 0;
        while (sent < n_items) begin
            case ($urandom_range(0, 7))
                0: len = '0;
                1: len = CFG_W'(1);
                2: len = CFG_W'(WINDOW_MAX);
                3: len = CFG_W'($urandom_range(WINDOW_MAX + 1, CFG_TOP));
                default: len = CFG_W'($urandom_range(1, WINDOW_MAX));
            endcase
            wait_drain();
            write_window(len);
            // Groups run long enough to fill and then slide most windows.
            group = $urandom_range(4, 60);
            for (int k = 0; k < group; k++) begin
                send_sample(random_sample(), k == group - 1, 1'b0, NO_MEAN);
            end
            sent += group;
        end
    endtask

    always @(posedge i_clk) begin : result_check
        t_mean want;
        if (i_rst_n && o_valid && i_ready) begin
            checked++;
            if (pending_means.size() == 0) begin
                $error("result with no request waiting: average %0d, samples_held %0d",
                       o_average, o_samples_held);
                errors++;
            end else begin
                want = pending_means.pop_front();
                if (o_average !== want.average) begin
                    $error("average: expected %0d, actual %0d", want.average, o_average);
                    errors++;
                end
                if (o_samples_held !== want.held) begin
                    $error("samples_held: expected %0d, actual %0d",
                           want.held, o_samples_held);
                    errors++;
                end
            end
        end
        i_ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        held_samples = '{default: '0};
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;

        for (int i = 0; i < DIR_ROWS; i++) begin
            t_dir_row row;
            bit       last_row;
            row      = directed[ROW_W'(i)];
            last_row = (i == DIR_ROWS - 1);
            if (!last_row) last_row = (directed[ROW_W'(i + 1)].kind == ROW_CFG);
            if (row.kind == ROW_CFG) begin
                wait_drain();
                write_window(row.value[CFG_W-1:0]);
            end else begin
                send_sample(row.value, last_row, row.typed, row.want);
            end
        end

        run_phase(25, 79, PHASE_ITEMS);
        run_phase(79, 25, PHASE_ITEMS);
        run_phase(0, 0, PHASE_ITEMS);

        wait_drain();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (pending_means.size() != 0) begin
            $error("%0d expected results never arrived", pending_means.size());
            errors++;
        end

        $display("Sent %0d sample requests and checked %0d results across %0d length writes.",
                 sent_total, checked, cfg_writes);
        $display("Lengths of zero, one, the full store and above it ran under mixed stalls.");
        if (errors == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end

endmodule

@@ boxcar_moving_average_top.f @@
hdl/bma_pkg.sv
hdl/bma_front.sv
hdl/bma_div.sv
hdl/bma_core.sv
hdl/boxcar_moving_average_top.sv
tb/boxcar_moving_average_top_tb.sv
